>>> design/assert_macros.svh
// assertion macros used by the checker file ptd_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PTD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define PTD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

>>> design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// types and constants of the priority task dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

	localparam int NAME_W  = 64;
	localparam int PRIO_W  = 8;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;

	typedef enum logic {
		OP_ADD      = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_ADDED      = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_DISP_SCAN,
		S_DISP_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t                 operation;
		logic [NAME_W-1:0]   task_name;
		logic [PRIO_W-1:0]   task_priority;
		logic [BURST_W-1:0]  task_burst;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [NAME_W-1:0]   chosen_name;
		logic [PRIO_W-1:0]   chosen_priority;
		logic [BURST_W-1:0]  chosen_burst;
		logic [TIME_W-1:0]   finish_time;
	} rsp_t;

endpackage

`default_nettype wire

>>> design/ptd_if.sv
// ----------------------------------------------------------------------------
// ptd_if
// request and result channels of the priority task dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [ptd_pkg::NAME_W-1:0]    task_name;
	logic [ptd_pkg::PRIO_W-1:0]    task_priority;
	logic [ptd_pkg::BURST_W-1:0]   task_burst;

	modport source (output valid, operation, task_name, task_priority, task_burst,
		input ready);
	modport sink (input valid, operation, task_name, task_priority, task_burst,
		output ready);
endinterface

interface ptd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptd_pkg::STAT_W-1:0]    status;
	logic [ptd_pkg::NAME_W-1:0]    chosen_name;
	logic [ptd_pkg::PRIO_W-1:0]    chosen_priority;
	logic [ptd_pkg::BURST_W-1:0]   chosen_burst;
	logic [ptd_pkg::TIME_W-1:0]    finish_time;

	modport source (output valid, status, chosen_name, chosen_priority, chosen_burst,
		finish_time, input ready);
	modport sink (input valid, status, chosen_name, chosen_priority, chosen_burst,
		finish_time, output ready);
endinterface

`default_nettype wire

>>> design/ptd_slot_mem.sv
// ----------------------------------------------------------------------------
// ptd_slot_mem
// task slot storage, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptd_slot_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 88
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/ptd_sched.sv
// ----------------------------------------------------------------------------
// ptd_sched
// slot scan sequencer: free slot search, best task search, commit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptd_sched #(
	parameter int TASK_SLOTS = 16,
	parameter int NAME_BYTES = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output      logic          req_ready,
	input  wire ptd_pkg::req_t req,
	input  wire logic          res_free,
	output      logic          res_done,
	output      ptd_pkg::rsp_t res
);

	localparam int IDX_W   = $clog2(TASK_SLOTS);
	localparam int NB_W    = NAME_BYTES * 8;
	localparam int ENTRY_W = NB_W + ptd_pkg::PRIO_W + ptd_pkg::BURST_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

	ptd_pkg::state_t state_q, state_d;

	ptd_pkg::op_t                   op_q;
	logic [NB_W-1:0]                name_q;
	logic [ptd_pkg::PRIO_W-1:0]     prio_q;
	logic [ptd_pkg::BURST_W-1:0]    burst_q;
	logic [IDX_W-1:0]               idx_q;
	logic [TASK_SLOTS-1:0]          valid_q;
	logic [ptd_pkg::TIME_W-1:0]     elapsed_q;
	logic                           found_q;

	logic [NB_W-1:0]                best_name_q;
	logic [ptd_pkg::PRIO_W-1:0]     best_prio_q;
	logic [ptd_pkg::BURST_W-1:0]    best_burst_q;
	logic [IDX_W-1:0]               best_idx_q;

	logic                           cmp_vld_s1;
	logic [IDX_W-1:0]               cmp_idx_s1;
	logic                           cmp_slot_vld_s1;

	logic                           mem_we;
	logic                           mem_re;
	logic [ENTRY_W-1:0]             mem_rdata;
	logic [NB_W-1:0]                rd_name;
	logic [ptd_pkg::PRIO_W-1:0]     rd_prio;
	logic [ptd_pkg::BURST_W-1:0]    rd_burst;

	logic                           accept;
	logic                           slot_free;
	logic                           take;
	logic                           commit_disp;
	logic [ptd_pkg::TIME_W-1:0]     finish_time;

	ptd_slot_mem #(
		.DEPTH (TASK_SLOTS),
		.WIDTH (ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_q),
		.wdata ({name_q, prio_q, burst_q}),
		.re    (mem_re),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	assign rd_name  = mem_rdata[ENTRY_W-1 -: NB_W];
	assign rd_prio  = mem_rdata[ptd_pkg::BURST_W +: ptd_pkg::PRIO_W];
	assign rd_burst = mem_rdata[ptd_pkg::BURST_W-1:0];

	assign accept    = req_valid && req_ready;
	assign slot_free = !valid_q[idx_q];

	// strictly better only, so the lowest index wins a full tie
	assign take = cmp_vld_s1 && cmp_slot_vld_s1 &&
		(!found_q || (rd_prio > best_prio_q) ||
		((rd_prio == best_prio_q) && (rd_name < best_name_q)));

	assign finish_time = elapsed_q + ptd_pkg::TIME_W'(best_burst_q);
	assign commit_disp = res_done && (op_q == ptd_pkg::OP_DISPATCH) && found_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptd_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = (req.operation == ptd_pkg::OP_ADD) ?
						ptd_pkg::S_ADD_SCAN : ptd_pkg::S_DISP_SCAN;
				end
			end
			ptd_pkg::S_ADD_SCAN: begin
				if (slot_free || (idx_q == LAST_IDX)) begin
					state_d = ptd_pkg::S_FINISH;
				end
			end
			ptd_pkg::S_DISP_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ptd_pkg::S_DISP_DRAIN;
				end
			end
			ptd_pkg::S_DISP_DRAIN: begin
				state_d = ptd_pkg::S_FINISH;
			end
			ptd_pkg::S_FINISH: begin
				if (res_free) begin
					state_d = ptd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ptd_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready = (state_q == ptd_pkg::S_IDLE);
		mem_we    = (state_q == ptd_pkg::S_ADD_SCAN) && slot_free;
		mem_re    = (state_q == ptd_pkg::S_DISP_SCAN);
		res_done  = (state_q == ptd_pkg::S_FINISH) && res_free;
		res       = '0;
		if (op_q == ptd_pkg::OP_ADD) begin
			res.status = found_q ? ptd_pkg::ST_ADDED : ptd_pkg::ST_FULL;
		end else if (found_q) begin
			res.status          = ptd_pkg::ST_DISPATCHED;
			res.chosen_name     = ptd_pkg::NAME_W'(best_name_q) << (ptd_pkg::NAME_W - NB_W);
			res.chosen_priority = best_prio_q;
			res.chosen_burst    = best_burst_q;
			res.finish_time     = finish_time;
		end else begin
			res.status = ptd_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ptd_pkg::S_IDLE;
			valid_q    <= '0;
			elapsed_q  <= '0;
			found_q    <= 1'b0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == ptd_pkg::S_DISP_SCAN);
			if (accept) begin
				found_q <= 1'b0;
			end else if (mem_we) begin
				found_q        <= 1'b1;
				valid_q[idx_q] <= 1'b1;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (commit_disp) begin
				valid_q[best_idx_q] <= 1'b0;
				elapsed_q           <= finish_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.operation;
			name_q  <= req.task_name[ptd_pkg::NAME_W-1 -: NB_W];
			prio_q  <= req.task_priority;
			burst_q <= req.task_burst;
			idx_q   <= '0;
		end else if ((state_q == ptd_pkg::S_ADD_SCAN) ||
			(state_q == ptd_pkg::S_DISP_SCAN)) begin
			idx_q <= idx_q + 1'b1;
		end
		cmp_idx_s1      <= idx_q;
		cmp_slot_vld_s1 <= valid_q[idx_q];
		if (take) begin
			best_name_q  <= rd_name;
			best_prio_q  <= rd_prio;
			best_burst_q <= rd_burst;
			best_idx_q   <= cmp_idx_s1;
		end
	end

endmodule

`default_nettype wire

>>> design/priority_task_dispatcher.sv
// add: the scan stops at the first free slot, or at the last slot of a full table;
//   a dispatch scans every slot and then passes the drain state
// flow: one request in flight; the next is taken once the result is registered,
//   and a dispatch scans one slot per cycle through the single read port
//   of the slot memory
// reset: clears slot valid bits, elapsed time and control at once, no clearing pass
// ----------------------------------------------------------------------------
// priority_task_dispatcher
// non-preemptive priority scheduler over a table of pending tasks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module priority_task_dispatcher #(
	parameter int TASK_SLOTS = 16,
	parameter int NAME_BYTES = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	ptd_req_if.sink  req,
	ptd_rsp_if.source rsp
);

	// request payload gathered into one struct for the sequencer
	ptd_pkg::req_t req_pl;
	ptd_pkg::rsp_t res;
	logic          res_done;
	logic          res_free;

	// result register, parts the sequencer from the result channel
	logic          rsp_valid_q;
	ptd_pkg::rsp_t rsp_q;

	assign req_pl.operation     = ptd_pkg::op_t'(req.operation);
	assign req_pl.task_name     = req.task_name;
	assign req_pl.task_priority = req.task_priority;
	assign req_pl.task_burst    = req.task_burst;

	// the register may be reloaded in the same cycle it is drained
	assign res_free = !rsp_valid_q || rsp.ready;

	ptd_sched #(
		.TASK_SLOTS (TASK_SLOTS),
		.NAME_BYTES (NAME_BYTES)
	) u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req_pl),
		.res_free  (res_free),
		.res_done  (res_done),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload needs no reset, it is qualified by the valid flag
	always_ff @(posedge clk) begin
		if (res_done) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.chosen_name     = rsp_q.chosen_name;
	assign rsp.chosen_priority = rsp_q.chosen_priority;
	assign rsp.chosen_burst    = rsp_q.chosen_burst;
	assign rsp.finish_time     = rsp_q.finish_time;

endmodule

`default_nettype wire

>>> design/ptd_chk.sv
// ----------------------------------------------------------------------------
// ptd_chk
// port-level checks of the priority task dispatcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ptd_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [ptd_pkg::STAT_W-1:0]    status,
	input wire logic [ptd_pkg::NAME_W-1:0]    chosen_name,
	input wire logic [ptd_pkg::PRIO_W-1:0]    chosen_priority,
	input wire logic [ptd_pkg::BURST_W-1:0]   chosen_burst,
	input wire logic [ptd_pkg::TIME_W-1:0]    finish_time
);

	// stalled result holds
	`PTD_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(finish_time) && $stable(chosen_name), "stalled result changed")

	// one request in flight: taking a request closes the request side
	`PTD_ASSERT(a_one_inflight, clk, arst_n, req_valid && req_ready |=> !req_ready, "request taken while busy")

	// an offered result always carries a defined status
	`PTD_ASSERT_NEVER(a_rsp_known, clk, arst_n, rsp_valid && $isunknown(status), "result status unknown")

	// only a dispatch carries task fields
	`PTD_ASSERT_NEVER(a_zero_fields, clk, arst_n, rsp_valid && (status != ptd_pkg::ST_DISPATCHED) && ((chosen_name != '0) || (chosen_priority != '0) || (chosen_burst != '0) || (finish_time != '0)), "non-dispatch result carries fields")

endmodule

bind priority_task_dispatcher ptd_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.chosen_name     (rsp.chosen_name),
	.chosen_priority (rsp.chosen_priority),
	.chosen_burst    (rsp.chosen_burst),
	.finish_time     (rsp.finish_time)
);

`default_nettype wire
